// ===== rtl/svpc_pkg.sv =====
// shared types, constants and command byte table for the servo pulse command unit
package svpc_pkg;

   localparam int PULSE_W     = 14;
   localparam int NUM_CH      = 4;
   localparam int CH_W        = 2;
   localparam int ANGLE_W     = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CMD_LEN     = 24;
   localparam int IDX_W       = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // n / 45 as (n * RECIP45) >> RECIP45_SHIFT, exact for n below 2**21
   localparam logic [22:0] RECIP45       = 23'd5965233;
   localparam int          RECIP45_SHIFT = 28;
   // v / 10 as (v * RECIP10) >> RECIP10_SHIFT, exact for v below 2**14
   localparam logic [15:0] RECIP10       = 16'd52429;
   localparam int          RECIP10_SHIFT = 19;

   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NUL   = 8'h00;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_HASH  = 8'h23;
   localparam logic [7:0] ASCII_P     = 8'h50;
   localparam logic [7:0] ASCII_S     = 8'h53;
   localparam logic [7:0] ASCII_ONE   = 8'h31;
   localparam logic [7:0] ASCII_LT    = 8'h3C;
   localparam logic [7:0] ASCII_C     = 8'h63;
   localparam logic [7:0] ASCII_R     = 8'h72;
   localparam logic [7:0] ASCII_GT    = 8'h3E;

   typedef struct packed {
      logic [PULSE_W-1:0] at_min;
      logic [PULSE_W-1:0] at_max;
   } svpc_pair_type;

   localparam svpc_pair_type PAIR_RESET [NUM_CH] = '{
      '{at_min: 14'd593,  at_max: 14'd2396},
      '{at_min: 14'd770,  at_max: 14'd1500},
      '{at_min: 14'd2439, at_max: 14'd649},
      '{at_min: 14'd2416, at_max: 14'd626}
   };

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [3:0][3:0]   digit;     // digit[3] thousands .. digit[0] units
   } svpc_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } svpc_qstat_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_DIV,
      F_SUM,
      F_DIGIT,
      F_PUSH
   } svpc_front_state_type;

   function automatic logic [7:0] cmd_byte(input logic [IDX_W-1:0] idx,
                                           input svpc_cmd_type cmd);
      logic [7:0] b;
      unique case (idx)
         5'd0:    b = ASCII_CR;
         5'd1:    b = ASCII_LF;
         5'd2:    b = ASCII_HASH;
         5'd3:    b = ASCII_ZERO + {6'd0, cmd.channel};
         5'd4:    b = ASCII_SPACE;
         5'd5:    b = ASCII_P;
         5'd6:    b = ASCII_ZERO + {4'd0, cmd.digit[3]};
         5'd7:    b = ASCII_ZERO + {4'd0, cmd.digit[2]};
         5'd8:    b = ASCII_ZERO + {4'd0, cmd.digit[1]};
         5'd9:    b = ASCII_ZERO + {4'd0, cmd.digit[0]};
         5'd10:   b = ASCII_SPACE;
         5'd11:   b = ASCII_S;
         5'd12:   b = ASCII_ONE;
         5'd13:   b = ASCII_ZERO;
         5'd14:   b = ASCII_ZERO;
         5'd15:   b = ASCII_ZERO;
         5'd16:   b = ASCII_SPACE;
         5'd17:   b = ASCII_LT;
         5'd18:   b = ASCII_C;
         5'd19:   b = ASCII_R;
         5'd20:   b = ASCII_GT;
         5'd21:   b = ASCII_CR;
         5'd22:   b = ASCII_LF;
         default: b = ASCII_NUL;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/svpc_front.sv =====
// front end: config registers, angle clamp, pulse mapping and decimal digit split
module svpc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wen,
   input  logic [svpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [svpc_pkg::PULSE_W-1:0]       csr_wdata,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [svpc_pkg::CH_W-1:0]          in_channel,
   input  logic signed [svpc_pkg::ANGLE_W-1:0] in_angle,
   output logic                               push,
   output svpc_pkg::svpc_cmd_type             push_data,
   input  svpc_pkg::svpc_qstat_type           qstat
);
   import svpc_pkg::*;

   svpc_pair_type         pair_ff [NUM_CH];
   svpc_front_state_type  state_ff, state_in;
   logic [1:0]            cnt_ff, cnt_in;

   logic [CH_W-1:0]            ch_ff;
   logic [7:0]                 a_ff;
   logic [PULSE_W-1:0]         p0_ff;
   logic signed [PULSE_W:0]    d_ff;
   logic                       half_ff;
   logic signed [23:0]         prod_ff;
   logic                       neg_ff;
   logic [43:0]                qprod_ff;
   logic [PULSE_W-1:0]         val_ff;
   logic [3:0][3:0]            dig_ff;

   logic                       accept;
   logic [7:0]                 a_in;
   logic signed [ANGLE_W:0]    ang_ext;
   logic signed [ANGLE_W:0]    ang_shift;
   svpc_pair_type              sel_pair;
   logic [22:0]                mag;
   logic [20:0]                div_n;
   logic [PULSE_W-1:0]         quo;
   logic signed [PULSE_W+1:0]  pulse_sum;
   logic [29:0]                d10_prod;
   logic [PULSE_W-1:0]         d10_q;
   logic [PULSE_W-1:0]         d10_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) pair_ff[i] <= PAIR_RESET[i];
      end else if (csr_wen) begin
         if (csr_index[0]) begin
            pair_ff[csr_index[CSR_INDEX_W-1:1]].at_max <= csr_wdata;
         end else begin
            pair_ff[csr_index[CSR_INDEX_W-1:1]].at_min <= csr_wdata;
         end
      end
   end

   assign accept    = in_valid && in_ready;
   assign sel_pair  = pair_ff[in_channel];
   assign ang_ext   = {in_angle[ANGLE_W-1], in_angle};
   assign ang_shift = ang_ext + 10'sd90;

   // clamp to the channel range and offset from its low end
   always_comb begin
      unique case (in_channel)
         2'd0: begin
            if (in_angle < 0)            a_in = 8'd0;
            else if (in_angle > 9'sd180) a_in = 8'd180;
            else                         a_in = in_angle[7:0];
         end
         2'd1: begin
            if (in_angle < 0)            a_in = 8'd0;
            else if (in_angle > 9'sd90)  a_in = 8'd90;
            else                         a_in = in_angle[7:0];
         end
         default: begin
            if (in_angle < -9'sd90)      a_in = 8'd0;
            else if (in_angle > 9'sd90)  a_in = 8'd180;
            else                         a_in = ang_shift[7:0];
         end
      endcase
   end

   assign mag       = neg_ff ? 23'(-prod_ff) : prod_ff[22:0];
   assign div_n     = half_ff ? mag[21:1] : mag[22:2];
   assign quo       = qprod_ff[RECIP45_SHIFT+PULSE_W-1:RECIP45_SHIFT];
   assign pulse_sum = neg_ff ? $signed({2'b00, p0_ff}) - $signed({2'b00, quo})
                             : $signed({2'b00, p0_ff}) + $signed({2'b00, quo});
   assign d10_prod  = val_ff * RECIP10;
   assign d10_q     = PULSE_W'(d10_prod[29:RECIP10_SHIFT]);
   assign d10_r     = val_ff - ({d10_q[PULSE_W-4:0], 3'b000} + {d10_q[PULSE_W-2:0], 1'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      in_ready = 1'b0;
      push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) state_in = F_MUL;
         end
         F_MUL: state_in = F_DIV;
         F_DIV: state_in = F_SUM;
         F_SUM: begin
            state_in = F_DIGIT;
            cnt_in   = 2'd0;
         end
         F_DIGIT: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!qstat.full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff   <= in_channel;
         a_ff    <= a_in;
         p0_ff   <= sel_pair.at_min;
         d_ff    <= $signed({1'b0, sel_pair.at_max}) - $signed({1'b0, sel_pair.at_min});
         half_ff <= (in_channel == 2'd1);
      end
      if (state_ff == F_MUL) begin
         prod_ff <= 24'(d_ff * $signed({1'b0, a_ff}));
         neg_ff  <= d_ff[PULSE_W];
      end
      if (state_ff == F_DIV) qprod_ff <= div_n * RECIP45;
      if (state_ff == F_SUM) val_ff <= pulse_sum[PULSE_W-1:0];
      if (state_ff == F_DIGIT) begin
         dig_ff[cnt_ff] <= d10_r[3:0];
         val_ff         <= d10_q;
      end
   end

   assign push_data.channel = ch_ff;
   assign push_data.digit   = dig_ff;

endmodule

// ===== rtl/svpc_queue.sv =====
// short command queue between front end and byte serializer
module svpc_queue #(
   parameter int DEPTH = svpc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  svpc_pkg::svpc_cmd_type    push_data,
   input  logic                      pop,
   output svpc_pkg::svpc_cmd_type    pop_data,
   output svpc_pkg::svpc_qstat_type  qstat
);
   import svpc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   svpc_cmd_type      mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (pop)  rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data    = mem_ff[rd_ff];
   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

// ===== rtl/svpc_back.sv =====
// back end: serializes one queued command into 24 bytes
module svpc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  svpc_pkg::svpc_cmd_type    pop_data,
   input  svpc_pkg::svpc_qstat_type  qstat,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                out_byte,
   output logic                      out_last
);
   import svpc_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CMD_LEN - 1);

   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   svpc_cmd_type      cmd_ff;
   logic              beat_done;

   assign beat_done = busy_ff && out_ready;
   assign pop       = !qstat.empty && (!busy_ff || (beat_done && idx_ff == LAST_IDX));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (beat_done) begin
         if (idx_ff == LAST_IDX) busy_in = 1'b0;
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cmd_ff <= pop_data;
   end

   assign out_valid = busy_ff;
   assign out_byte  = cmd_byte(idx_ff, cmd_ff);
   assign out_last  = (idx_ff == LAST_IDX);

endmodule

// ===== rtl/servo_angle_pulse_command_unit.sv =====
// top level of the servo angle to pulse width command unit
//
// req channel: one beat carries a servo channel and a signed angle in degrees.
// the angle is clamped to the channel range, mapped linearly between the two
// pulse endpoints of that channel and turned into a 24 byte ascii move
// command that leaves on the rsp channel one byte per beat, tlast on the
// final nul byte.
// csr port: csr_wen writes csr_wdata into the endpoint register csr_index.
// write only while no command is in flight; the block does not enforce this.
// path: a req beat passes the front end mul, div, sum, digit and push states,
// the queue and the byte serializer, which sets the throughput; the front end
// takes one beat at a time and runs ahead by up to the queue depth.
// reset: all endpoints return to their defaults and the queue empties.
// when rsp_tready is low the current byte holds; the queue then fills and
// req_tready drops until the serializer takes the next command.
module servo_angle_pulse_command_unit #(
   parameter int QUEUE_DEPTH = svpc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [svpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [svpc_pkg::PULSE_W-1:0]      csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // channel, angle_deg
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // out_byte
   output logic                              rsp_tlast
);
   import svpc_pkg::*;

   logic            push;
   logic            pop;
   svpc_cmd_type    push_data;
   svpc_cmd_type    pop_data;
   svpc_qstat_type  qstat;

   svpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_channel (req_tdata[1:0]),
      .in_angle   ($signed(req_tdata[10:2])),
      .push       (push),
      .push_data  (push_data),
      .qstat      (qstat)
   );

   svpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   svpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .qstat     (qstat),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== tb/tb_servo_angle_pulse_command_unit.sv =====
// self-checking testbench for the servo angle to pulse width command unit
`timescale 1ns / 100ps

module tb_servo_angle_pulse_command_unit;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RAND_PER_SET = 55;
   localparam int MAX_PRINTS   = 40;
   localparam int ANGLE_LO [4] = '{0, 0, -90, -90};
   localparam int ANGLE_HI [4] = '{180, 90, 90, 90};

   typedef enum logic [svpc_pkg::CSR_INDEX_W-1:0] {
      REG_CH0_AT_MIN,
      REG_CH0_AT_MAX,
      REG_CH1_AT_MIN,
      REG_CH1_AT_MAX,
      REG_CH2_AT_MIN,
      REG_CH2_AT_MAX,
      REG_CH3_AT_MIN,
      REG_CH3_AT_MAX
   } endpoint_reg_type;

   typedef enum logic [1:0] {
      RX_FREE,
      RX_COIN,
      RX_SPARSE,
      RX_BURSTY
   } rx_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } cmd_beat_type;

   typedef logic [svpc_pkg::PULSE_W-1:0] endpoint_set_type [8];

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             csr_wen    = 1'b0;
   logic [svpc_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [svpc_pkg::PULSE_W-1:0]     csr_wdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [15:0]                      req_tdata  = '0;   // channel, angle_deg
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [7:0]                       rsp_tdata;         // out_byte
   logic                             rsp_tlast;

   logic [svpc_pkg::PULSE_W-1:0] endpoint [8];
   logic [15:0]                  pend_items [$];
   cmd_beat_type                 cmd_beats_due [$];

   int          err_count    = 0;
   int          cmds_done    = 0;
   int          items_sent   = 0;
   int          beat_pos     = 0;
   int          settings_run = 0;
   int          cycle_count  = 0;
   int          gap_left     = 0;
   int          burst_left   = 0;
   int          stall_span   = 0;
   rx_mode_type stall_mode   = RX_FREE;

   servo_angle_pulse_command_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic note_mismatch(input string msg);
      if (err_count < MAX_PRINTS)
         $display("mismatch at cycle %0d, command %0d byte %0d: %s",
                  cycle_count, cmds_done, beat_pos, msg);
      err_count++;
   endtask

   function automatic int unsigned pulse_width(input logic [1:0] ch,
                                               input logic signed [8:0] ang);
      int a;
      int lo;
      int hi;
      int p0;
      int p1;
      int p;
      a  = ang;
      lo = ANGLE_LO[ch];
      hi = ANGLE_HI[ch];
      if (a < lo) a = lo;
      if (a > hi) a = hi;
      p0 = int'(endpoint[{ch, 1'b0}]);
      p1 = int'(endpoint[{ch, 1'b1}]);
      p  = p0 + ((p1 - p0) * (a - lo)) / (hi - lo);
      return (p < 0) ? 0 : p;
   endfunction

   function automatic logic [7:0] ascii_digit(input int unsigned v);
      return 8'(8'h30 + v % 10);
   endfunction

   task automatic queue_move_command(input logic [1:0] ch, input logic signed [8:0] ang);
      logic [7:0]  txt [svpc_pkg::CMD_LEN];
      int unsigned pw;
      pw  = pulse_width(ch, ang);
      txt = '{8'h0D, 8'h0A, "#", 8'(8'h30 + ch), " ", "P",
              ascii_digit(pw / 1000), ascii_digit(pw / 100),
              ascii_digit(pw / 10), ascii_digit(pw),
              " ", "S", "1", "0", "0", "0", " ", "<", "c", "r", ">",
              8'h0D, 8'h0A, 8'h00};
      for (int k = 0; k < svpc_pkg::CMD_LEN; k++)
         cmd_beats_due.push_back('{data: txt[k], last: (k == svpc_pkg::CMD_LEN - 1)});
   endtask

   task automatic add_item(input int ch, input int ang);
      pend_items.push_back({5'd0, 9'(ang), 2'(ch)});
   endtask

   task automatic add_random_items(input int count);
      int ch;
      int ang;
      for (int i = 0; i < count; i++) begin
         ch = $urandom_range(0, 3);
         if ($urandom_range(0, 1) == 0)
            ang = $urandom_range(0, 511);
         else
            ang = ANGLE_LO[ch] + $urandom_range(0, ANGLE_HI[ch] - ANGLE_LO[ch]);
         add_item(ch, ang);
      end
   endtask

   task automatic program_endpoints(input endpoint_set_type vals);
      for (int r = 0; r < 8; r++) begin
         @(posedge clock);
         csr_wen   <= 1'b1;
         csr_index <= endpoint_reg_type'(r);
         csr_wdata <= vals[r];
         endpoint[r] = vals[r];
      end
      @(posedge clock);
      csr_wen <= 1'b0;
      settings_run++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pend_items.size() != 0 || req_tvalid || cmd_beats_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // req side: bursts of beats with random gaps
   always @(posedge clock) begin : req_driver
      logic        hold;
      logic        nxt_valid;
      logic [15:0] nxt_data;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         gap_left   = 0;
         burst_left = 0;
      end else begin
         nxt_valid = req_tvalid;
         nxt_data  = req_tdata;
         hold      = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            queue_move_command(req_tdata[1:0], req_tdata[10:2]);
            items_sent++;
            nxt_valid = 1'b0;
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pend_items.size() != 0) begin
               nxt_data  = pend_items.pop_front();
               nxt_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
         req_tvalid <= nxt_valid;
         req_tdata  <= nxt_data;
      end
   end

   // rsp side: stall pattern that changes mode every so often
   always @(posedge clock) begin : rsp_stall
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_span = 0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 200);
         end else begin
            stall_span--;
         end
         case (stall_mode)
            RX_FREE:   rdy = 1'b1;
            RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
            RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
            default:   rdy = ((stall_span % 16) < 6);
         endcase
         rsp_tready <= rdy;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      cmd_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cmd_beats_due.size() == 0) begin
            note_mismatch($sformatf("unexpected byte %02h last %b", rsp_tdata, rsp_tlast));
         end else begin
            want = cmd_beats_due.pop_front();
            if (rsp_tdata !== want.data)
               note_mismatch($sformatf("out_byte %02h, want %02h", rsp_tdata, want.data));
            if (rsp_tlast !== want.last)
               note_mismatch($sformatf("last_byte %b, want %b", rsp_tlast, want.last));
            if (want.last) begin
               cmds_done++;
               beat_pos = 0;
            end else begin
               beat_pos++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d bytes outstanding", cmd_beats_due.size());
         $display("[servo_angle_pulse_command_unit] ERROR");
         $finish;
      end
   end

   initial begin : main_seq
      endpoint_set_type vals;
      endpoint = '{14'd593, 14'd2396, 14'd770, 14'd1500,
                   14'd2439, 14'd649, 14'd2416, 14'd626};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults: range ends, saturation on both sides, sign bit extremes
      add_item(0, 0);   add_item(0, 180); add_item(0, 90);  add_item(0, -1);
      add_item(0, 181); add_item(0, 255); add_item(0, -256);
      add_item(1, 0);   add_item(1, 90);  add_item(1, 45);  add_item(1, 91);
      add_item(1, -90);
      add_item(2, -90); add_item(2, 90);  add_item(2, 0);   add_item(2, -91);
      add_item(2, 91);  add_item(2, 1);
      add_item(3, -90); add_item(3, 90);  add_item(3, -45); add_item(3, 255);
      add_item(3, -256); add_item(3, 45);
      wait_idle();

      for (int s = 0; s < 7; s++) begin
         for (int r = 0; r < 8; r++) begin
            case (s)
               0:       vals[r] = r[0] ? 14'h3FFF : 14'h0000;
               1:       vals[r] = r[0] ? 14'h0000 : 14'h3FFF;
               2:       vals[r] = 14'h0000;
               3:       vals[r] = 14'h3FFF;
               6:       vals[r] = 14'($urandom_range(0, 16383));
               default: vals[r] = 14'($urandom_range(0, 9999));
            endcase
         end
         program_endpoints(vals);
         @(negedge clock);
         add_random_items(RAND_PER_SET);
         wait_idle();
      end

      $display("%0d commands checked from %0d request beats", cmds_done, items_sent);
      $display("defaults plus %0d endpoint settings, %0d mismatches", settings_run, err_count);
      if (err_count == 0)
         $display("[servo_angle_pulse_command_unit] OK");
      else
         $display("[servo_angle_pulse_command_unit] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/svpc_pkg.sv
rtl/svpc_front.sv
rtl/svpc_queue.sv
rtl/svpc_back.sv
rtl/servo_angle_pulse_command_unit.sv
tb/tb_servo_angle_pulse_command_unit.sv
